// File: hdl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// File: hdl/irm_pkg.sv
// types and constants for the i2c register access master
// no dependencies
package irm_pkg;

   localparam int MAX_BURST_DEFAULT = 16;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;
   localparam logic [7:0] DEV_WRITE_MASK = 8'hFE;
   localparam logic [7:0] DEV_READ_BIT = 8'h01;
   localparam logic CSR_PHASE_TICKS = 1'b0;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_S_SETUP = 5'd1,
      PH_S_HOLD  = 5'd2,
      PH_S_LOW   = 5'd3,
      PH_DEV_LO  = 5'd4,
      PH_DEV_HI  = 5'd5,
      PH_DEV_AL  = 5'd6,
      PH_DEV_AH  = 5'd7,
      PH_REG_LO  = 5'd8,
      PH_REG_HI  = 5'd9,
      PH_REG_AL  = 5'd10,
      PH_REG_AH  = 5'd11,
      PH_WD_LO   = 5'd12,
      PH_WD_HI   = 5'd13,
      PH_WD_AL   = 5'd14,
      PH_WD_AH   = 5'd15,
      PH_RS_REL  = 5'd16,
      PH_RS_HIGH = 5'd17,
      PH_RS_HOLD = 5'd18,
      PH_RS_LOW  = 5'd19,
      PH_RDEV_LO = 5'd20,
      PH_RDEV_HI = 5'd21,
      PH_RDEV_AL = 5'd22,
      PH_RDEV_AH = 5'd23,
      PH_RD_LO   = 5'd24,
      PH_RD_HI   = 5'd25,
      PH_MACK_LO = 5'd26,
      PH_MACK_HI = 5'd27,
      PH_P_LOW   = 5'd28,
      PH_P_HIGH  = 5'd29,
      PH_P_END   = 5'd30
   } phase_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       write_data_taken;
      logic       ack_missing;
      logic       done_res;
   } rsp_type;

endpackage

// File: hdl/i2c_register_access_master_top.sv
// i2c register access master: one item per tick, bus sequencer with phase timer
// the result of an item is registered in the output register, or in the skid stage while rsp is stalled
// throughput: one item per cycle while the skid stage is empty, output register plus skid stage
// the phase timer and sequencer advance once per accepted item, setting bus timing
// reset (synchronous): sequencer idle, state cleared, phase_ticks 5, rsp empty
// depends on irm_pkg
module i2c_register_access_master_top
   import irm_pkg::*;
#(
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_sda_in,
   input  logic        req_start_req,
   input  logic        req_operation,
   input  logic [7:0]  req_device_address,
   input  logic [7:0]  req_register_address,
   input  logic [4:0]  req_byte_count,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_write_data_taken,
   output logic        rsp_ack_missing,
   output logic        rsp_done_res,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int BLW = $clog2(MAX_BURST + 1);

   logic [15:0]    phase_ticks_ff;
   phase_type      phase_ff, phase_in;
   logic [3:0]     bit_ff, bit_in;
   logic [BLW-1:0] left_ff, left_in, left_dec, left_start;
   logic [7:0]     shift_ff, shift_in;
   logic [15:0]    timer_ff, timer_in;
   logic [7:0]     dev_ff, dev_in;
   logic [7:0]     reg_ff, reg_in;
   logic           op_ff, op_in;
   logic           nack_ff, nack_in;
   logic [7:0]     last_ff, last_in;
   logic           rvalid, taken, done;
   logic [15:0]    ticks;
   logic           accept;
   rsp_type        result;
   rsp_type        out_ff, skid_ff;
   logic           out_valid_ff, skid_valid_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_PHASE_TICKS) ? {16'd0, phase_ticks_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == CSR_PHASE_TICKS) begin
         phase_ticks_ff <= csr_pwdata[15:0];
      end
   end

   assign ticks = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign left_dec = (left_ff != '0) ? left_ff - BLW'(1) : left_ff;

   always_comb begin
      if (req_byte_count == 5'd0) begin
         left_start = BLW'(1);
      end else if (32'(req_byte_count) > MAX_BURST) begin
         left_start = BLW'(MAX_BURST);
      end else begin
         left_start = BLW'(req_byte_count);
      end
   end

   // next state of the sequencer
   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      left_in  = left_ff;
      shift_in = shift_ff;
      timer_in = timer_ff;
      dev_in   = dev_ff;
      reg_in   = reg_ff;
      op_in    = op_ff;
      nack_in  = nack_ff;
      last_in  = last_ff;
      rvalid   = 1'b0;
      taken    = 1'b0;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (req_start_req) begin
            op_in    = req_operation;
            dev_in   = req_device_address;
            reg_in   = req_register_address;
            left_in  = left_start;
            nack_in  = 1'b0;
            bit_in   = 4'd0;
            shift_in = 8'd0;
            timer_in = 16'd0;
            phase_in = PH_S_SETUP;
         end
      end else if ({1'b0, timer_ff} + 17'd1 < {1'b0, ticks}) begin
         timer_in = timer_ff + 16'd1;
      end else begin
         timer_in = 16'd0;
         unique case (phase_ff)
            PH_DEV_LO, PH_REG_LO, PH_WD_LO, PH_RDEV_LO,
            PH_DEV_AL, PH_REG_AL, PH_WD_AL, PH_RDEV_AL: begin
               phase_in = phase_type'(phase_ff + 5'd1);
            end
            PH_DEV_HI, PH_REG_HI, PH_WD_HI, PH_RDEV_HI: begin
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_ff + 4'd1;
               phase_in = (bit_in >= 4'd8) ? phase_type'(phase_ff + 5'd1)
                                           : phase_type'(phase_ff - 5'd1);
            end
            PH_DEV_AH: begin
               if (req_sda_in) nack_in = 1'b1;
               phase_in = PH_REG_LO;
               shift_in = reg_ff;
               bit_in   = 4'd0;
            end
            PH_REG_AH: begin
               if (req_sda_in) nack_in = 1'b1;
               if (!op_ff) begin
                  phase_in = PH_WD_LO;
                  shift_in = req_write_data;
                  bit_in   = 4'd0;
                  taken    = 1'b1;
               end else begin
                  phase_in = PH_RS_REL;
               end
            end
            PH_WD_AH: begin
               if (req_sda_in) nack_in = 1'b1;
               left_in = left_dec;
               if (left_dec != '0) begin
                  phase_in = PH_WD_LO;
                  shift_in = req_write_data;
                  bit_in   = 4'd0;
                  taken    = 1'b1;
               end else begin
                  phase_in = PH_P_LOW;
               end
            end
            PH_RDEV_AH: begin
               if (req_sda_in) nack_in = 1'b1;
               phase_in = PH_RD_LO;
               shift_in = 8'd0;
               bit_in   = 4'd0;
            end
            PH_S_SETUP: phase_in = PH_S_HOLD;
            PH_S_HOLD:  phase_in = PH_S_LOW;
            PH_S_LOW: begin
               phase_in = PH_DEV_LO;
               shift_in = dev_ff & DEV_WRITE_MASK;
               bit_in   = 4'd0;
            end
            PH_RS_REL:  phase_in = PH_RS_HIGH;
            PH_RS_HIGH: phase_in = PH_RS_HOLD;
            PH_RS_HOLD: phase_in = PH_RS_LOW;
            PH_RS_LOW: begin
               phase_in = PH_RDEV_LO;
               shift_in = dev_ff | DEV_READ_BIT;
               bit_in   = 4'd0;
            end
            PH_RD_LO: phase_in = PH_RD_HI;
            PH_RD_HI: begin
               shift_in = {shift_ff[6:0], req_sda_in};
               bit_in   = bit_ff + 4'd1;
               if (bit_in >= 4'd8) begin
                  last_in  = shift_in;
                  rvalid   = 1'b1;
                  left_in  = left_dec;
                  phase_in = PH_MACK_LO;
               end else begin
                  phase_in = PH_RD_LO;
               end
            end
            PH_MACK_LO: phase_in = PH_MACK_HI;
            PH_MACK_HI: begin
               if (left_ff != '0) begin
                  phase_in = PH_RD_LO;
                  shift_in = 8'd0;
                  bit_in   = 4'd0;
               end else begin
                  phase_in = PH_P_LOW;
               end
            end
            PH_P_LOW:  phase_in = PH_P_HIGH;
            PH_P_HIGH: phase_in = PH_P_END;
            PH_P_END: begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // bus levels and result for the phase being entered (phase_in)
   always_comb begin
      result.scl_level   = 1'b1;
      result.sda_release = 1'b1;
      unique case (phase_in)
         PH_DEV_LO, PH_REG_LO, PH_WD_LO, PH_RDEV_LO: begin
            result.scl_level   = 1'b0;
            result.sda_release = shift_in[7];
         end
         PH_DEV_HI, PH_REG_HI, PH_WD_HI, PH_RDEV_HI: begin
            result.scl_level   = 1'b1;
            result.sda_release = shift_in[7];
         end
         PH_DEV_AL, PH_REG_AL, PH_WD_AL, PH_RDEV_AL, PH_RS_REL, PH_RD_LO: begin
            result.scl_level   = 1'b0;
            result.sda_release = 1'b1;
         end
         PH_S_HOLD, PH_RS_HOLD, PH_P_HIGH: begin
            result.scl_level   = 1'b1;
            result.sda_release = 1'b0;
         end
         PH_S_LOW, PH_RS_LOW, PH_P_LOW: begin
            result.scl_level   = 1'b0;
            result.sda_release = 1'b0;
         end
         PH_MACK_LO: begin
            result.scl_level   = 1'b0;
            result.sda_release = (left_in == '0);
         end
         PH_MACK_HI: begin
            result.scl_level   = 1'b1;
            result.sda_release = (left_in == '0);
         end
         default: begin
            result.scl_level   = 1'b1;
            result.sda_release = 1'b1;
         end
      endcase
      result.busy_res         = (phase_in != PH_IDLE);
      result.read_data        = last_in;
      result.read_valid       = rvalid;
      result.write_data_taken = taken;
      result.ack_missing      = nack_in;
      result.done_res         = done;
   end

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 4'd0;
         left_ff  <= '0;
         shift_ff <= 8'd0;
         timer_ff <= 16'd0;
         dev_ff   <= 8'd0;
         reg_ff   <= 8'd0;
         op_ff    <= 1'b0;
         nack_ff  <= 1'b0;
         last_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         left_ff  <= left_in;
         shift_ff <= shift_in;
         timer_ff <= timer_in;
         dev_ff   <= dev_in;
         reg_ff   <= reg_in;
         op_ff    <= op_in;
         nack_ff  <= nack_in;
         last_ff  <= last_in;
      end
   end

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_scl_level        = out_ff.scl_level;
   assign rsp_sda_release      = out_ff.sda_release;
   assign rsp_busy_res         = out_ff.busy_res;
   assign rsp_read_data        = out_ff.read_data;
   assign rsp_read_valid       = out_ff.read_valid;
   assign rsp_write_data_taken = out_ff.write_data_taken;
   assign rsp_ack_missing      = out_ff.ack_missing;
   assign rsp_done_res         = out_ff.done_res;

endmodule

// File: hdl/irm_checker.sv
// port-level checks for the i2c register access master, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module irm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_level,
   input logic       rsp_sda_release,
   input logic       rsp_busy_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_read_valid,
   input logic       rsp_write_data_taken,
   input logic       rsp_done_res
);

   // stalled item holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data))
   // stop completes with the sequencer idle
   `CHK_IMPL(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   // idle bus lines released high
   `CHK_IMPL(a_idle_lines, clock, reset, rsp_valid && !rsp_busy_res, rsp_scl_level && rsp_sda_release)
   // a received byte and a taken write byte never share an item
   `CHK_IMPL(a_rd_wr_excl, clock, reset, rsp_valid && rsp_read_valid, !rsp_write_data_taken)

endmodule

bind i2c_register_access_master_top irm_checker u_irm_checker (.*);
